/* rtl/dqqp_pkg.sv */
// ----------------------------------------------------------------------------
// dqqp_pkg
// Shared types and constants for the DNS query question parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dqqp_pkg;

	localparam int unsigned HEADER_BYTES   = 12;
	localparam int unsigned MAX_NAME_CHARS = 255;

	// Header byte positions that hold the flags.
	localparam logic [3:0] FLAGS_HIGH_POS = 4'd2;
	localparam logic [3:0] FLAGS_LOW_POS  = 4'd3;

	// Flag bit masks and codes.
	localparam logic [7:0] QR_RA_MASK       = 8'd128;
	localparam logic [7:0] RCODE_KEEP_MASK  = 8'd240;
	localparam logic [7:0] RCODE_NOT_IMPL   = 8'd4;
	localparam logic [7:0] DOT_CHAR         = 8'h2E;

	localparam logic RESULT_CHAR    = 1'b0;
	localparam logic RESULT_SUMMARY = 1'b1;

	localparam logic [15:0] SUPPORTED_TYPE_RESET = 16'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_start;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  name_char;
		logic [15:0] question_type;
		logic [7:0]  flags_high;
		logic [7:0]  flags_low;
		logic        not_implemented;
		logic [7:0]  name_length;
		logic        name_overflow;
	} out_item_t;

endpackage

`default_nettype wire

/* rtl/dns_query_question_parser.sv */
// ----------------------------------------------------------------------------
// dns_query_question_parser
// Byte-wide DNS question parser: emits name characters and a query summary.
// ----------------------------------------------------------------------------
//   Channel   Handshake             Payload                 Width
//   input     in_valid / in_stall   in_item  (in_item_t)    9
//   output    out_valid / out_stall out_item (out_item_t)   51
//   config    cfg_wr_en             cfg_wr_data             16
//
// One byte is taken every cycle while the input register is not held. A byte
// sits in the input register, where the parse state is updated, and any
// result it causes moves from there into the output register, from which it
// is offered on out_item.
// Reset clears the parse state to the header phase and the supported type to 1.
// A byte that causes a result waits in the input register while the output
// register is full and stalled; bytes that cause no result are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_query_question_parser #(
	parameter int unsigned HEADER_BYTES   = dqqp_pkg::HEADER_BYTES,
	parameter int unsigned MAX_NAME_CHARS = dqqp_pkg::MAX_NAME_CHARS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [15:0]         cfg_wr_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire dqqp_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output dqqp_pkg::out_item_t      out_item
);

	logic [15:0]         supported_q;
	logic                in_valid_s1;
	dqqp_pkg::in_item_t  in_item_s1;
	logic                out_valid_s2;
	dqqp_pkg::out_item_t out_item_s2;

	logic                emit;
	dqqp_pkg::out_item_t result;
	logic                out_free;
	logic                s1_fire;

	assign out_free = !out_valid_s2 || !out_stall;
	assign s1_fire  = in_valid_s1 && (!emit || out_free);
	assign in_stall = in_valid_s1 && !s1_fire;

	dqqp_parser #(
		.HEADER_BYTES   (HEADER_BYTES),
		.MAX_NAME_CHARS (MAX_NAME_CHARS)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (in_item_s1),
		.advance        (s1_fire),
		.supported_type (supported_q),
		.emit           (emit),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supported_q <= dqqp_pkg::SUPPORTED_TYPE_RESET;
		end else if (cfg_wr_en) begin
			supported_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			in_valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s1_fire && emit) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			out_item_s2 <= result;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_item  = out_item_s2;

endmodule

`default_nettype wire

/* rtl/dqqp_parser.sv */
// ----------------------------------------------------------------------------
// dqqp_parser
// Per-packet parse state and the combinational next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module dqqp_parser #(
	parameter int unsigned HEADER_BYTES   = dqqp_pkg::HEADER_BYTES,
	parameter int unsigned MAX_NAME_CHARS = dqqp_pkg::MAX_NAME_CHARS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dqqp_pkg::in_item_t item,
	input  wire logic               advance,
	input  wire logic [15:0]        supported_type,
	output logic                    emit,
	output dqqp_pkg::out_item_t     result
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_CHARS,
		PH_TYPE_HI,
		PH_TYPE_LO,
		PH_DONE
	} phase_t;

	localparam logic [3:0] HeaderLast = 4'(HEADER_BYTES - 1);
	localparam logic [7:0] MaxChars   = 8'(MAX_NAME_CHARS);

	phase_t      phase_q,      phase_d;
	logic [3:0]  header_cnt_q, header_cnt_d;
	logic [7:0]  label_rem_q,  label_rem_d;
	logic        first_label_q, first_label_d;
	logic [7:0]  flags_high_q, flags_high_d;
	logic [7:0]  flags_low_q,  flags_low_d;
	logic [7:0]  type_high_q,  type_high_d;
	logic [7:0]  char_cnt_q,   char_cnt_d;
	logic        overflow_q,   overflow_d;

	always_comb begin
		phase_t      ph;
		logic [3:0]  hc;
		logic [7:0]  lr;
		logic        fl1;
		logic [7:0]  fh;
		logic [7:0]  flo;
		logic [7:0]  th;
		logic [7:0]  cc;
		logic        ov;
		logic        want_char;
		logic [7:0]  ch;
		logic [15:0] qtype;
		logic [7:0]  fh_out;
		logic [7:0]  fl_out;
		logic        notimp;

		// A packet start discards whatever the previous packet left behind.
		if (item.packet_start) begin
			ph  = PH_HEADER;
			hc  = '0;
			lr  = '0;
			fl1 = 1'b1;
			fh  = '0;
			flo = '0;
			th  = '0;
			cc  = '0;
			ov  = 1'b0;
		end else begin
			ph  = phase_q;
			hc  = header_cnt_q;
			lr  = label_rem_q;
			fl1 = first_label_q;
			fh  = flags_high_q;
			flo = flags_low_q;
			th  = type_high_q;
			cc  = char_cnt_q;
			ov  = overflow_q;
		end

		phase_d       = ph;
		header_cnt_d  = hc;
		label_rem_d   = lr;
		first_label_d = fl1;
		flags_high_d  = fh;
		flags_low_d   = flo;
		type_high_d   = th;
		char_cnt_d    = cc;
		overflow_d    = ov;
		want_char     = 1'b0;
		ch            = item.data_byte;
		emit          = 1'b0;
		result        = '0;
		qtype         = {th, item.data_byte};
		notimp        = (qtype != supported_type);
		fh_out        = fh;
		fl_out        = flo;

		unique case (ph)
			PH_HEADER: begin
				if (hc == dqqp_pkg::FLAGS_HIGH_POS) begin
					flags_high_d = item.data_byte;
				end else if (hc == dqqp_pkg::FLAGS_LOW_POS) begin
					flags_low_d = item.data_byte;
				end
				header_cnt_d = hc + 4'd1;
				if (hc >= HeaderLast) begin
					phase_d = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				if (item.data_byte == 8'd0) begin
					phase_d = PH_TYPE_HI;
				end else begin
					label_rem_d = item.data_byte;
					phase_d     = PH_CHARS;
					want_char   = !fl1;
					ch          = dqqp_pkg::DOT_CHAR;
				end
			end
			PH_CHARS: begin
				label_rem_d = lr - 8'd1;
				if (lr == 8'd1) begin
					first_label_d = 1'b0;
					phase_d       = PH_LENGTH;
				end
				want_char = 1'b1;
			end
			PH_TYPE_HI: begin
				type_high_d = item.data_byte;
				phase_d     = PH_TYPE_LO;
			end
			PH_TYPE_LO: begin
				if (fh[0]) begin
					fl_out = fl_out | dqqp_pkg::QR_RA_MASK;
				end
				if (notimp) begin
					fh_out = fh_out | dqqp_pkg::QR_RA_MASK;
					fl_out = (fl_out & dqqp_pkg::RCODE_KEEP_MASK) | dqqp_pkg::RCODE_NOT_IMPL;
				end
				phase_d                = PH_DONE;
				emit                   = 1'b1;
				result.result_kind     = dqqp_pkg::RESULT_SUMMARY;
				result.question_type   = qtype;
				result.flags_high      = fh_out;
				result.flags_low       = fl_out;
				result.not_implemented = notimp;
				result.name_length     = cc;
				result.name_overflow   = ov;
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		// Characters past the length limit are dropped but still parsed.
		if (want_char) begin
			if (cc >= MaxChars) begin
				overflow_d = 1'b1;
			end else begin
				char_cnt_d         = cc + 8'd1;
				emit               = 1'b1;
				result.result_kind = dqqp_pkg::RESULT_CHAR;
				result.name_char   = ch;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			header_cnt_q  <= '0;
			label_rem_q   <= '0;
			first_label_q <= 1'b1;
			flags_high_q  <= '0;
			flags_low_q   <= '0;
			type_high_q   <= '0;
			char_cnt_q    <= '0;
			overflow_q    <= 1'b0;
		end else if (advance) begin
			phase_q       <= phase_d;
			header_cnt_q  <= header_cnt_d;
			label_rem_q   <= label_rem_d;
			first_label_q <= first_label_d;
			flags_high_q  <= flags_high_d;
			flags_low_q   <= flags_low_d;
			type_high_q   <= type_high_d;
			char_cnt_q    <= char_cnt_d;
			overflow_q    <= overflow_d;
		end
	end

endmodule

`default_nettype wire
